// ===== hdl/cau_pkg.sv =====
// Shared types, widths and codes of the complex arithmetic unit.
`default_nettype none

package cau_pkg;

    // Fixed widths of the operand and result fields.
    localparam int DATA_W = 32;
    localparam int PROD_W = 64;
    localparam int SUM_W = 66;
    localparam int MAG_W = 35;

    // Quotient bits produced by the divider and root bits produced by the square root.
    localparam int QBITS = 33;
    localparam int ROOT_STEPS = 32;
    localparam int ROOT_REM_W = 35;

    // Defaults for the top-level parameters.
    localparam int FRAC_BITS = 16;
    localparam int QUEUE_DEPTH = 2;

    // Result status codes.
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    // Operation classes; unused action codes map to OP_NOP.
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MAG = 3'd4,
        OP_NEG = 3'd5,
        OP_NOP = 3'd6
    } op_t;

    // One classified request as held in the queue.
    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] ar;
        logic signed [DATA_W-1:0] ai;
        logic signed [DATA_W-1:0] br;
        logic signed [DATA_W-1:0] bi;
    } req_t;

    // Products and raw sums after the multiply stage.
    typedef struct packed {
        op_t                      op;
        logic signed [PROD_W-1:0] p1;
        logic signed [PROD_W-1:0] p2;
        logic signed [PROD_W-1:0] p3;
        logic signed [PROD_W-1:0] p4;
        logic signed [PROD_W-1:0] p5;
        logic signed [PROD_W-1:0] p6;
        logic signed [DATA_W:0]   sre;
        logic signed [DATA_W:0]   sim;
    } prod_t;

    // Exact real and imaginary sums and the squared norm.
    typedef struct packed {
        op_t                     op;
        logic signed [SUM_W-1:0] t1;
        logic signed [SUM_W-1:0] t2;
        logic [PROD_W-1:0]       den;
    } sum_t;

    // One result part: divider state or, for other operations, the final magnitude.
    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [QBITS-1:0]  num;
        logic [MAG_W-1:0]  quo;
        logic              neg;
        logic              sat;
    } lane_t;

    // Square root state.
    typedef struct packed {
        logic [ROOT_REM_W-1:0] rem;
        logic [ROOT_STEPS-1:0] root;
        logic [PROD_W-1:0]     rad;
    } root_t;

    // One item in the iteration pipeline.
    typedef struct packed {
        op_t               op;
        logic              div0;
        logic [PROD_W-1:0] den;
        lane_t             l0;
        lane_t             l1;
        root_t             sq;
    } item_t;

    // Saturated result part.
    typedef struct packed {
        logic              ovf;
        logic [DATA_W-1:0] val;
    } sat_t;

endpackage

`default_nettype wire

// ===== hdl/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit.
`default_nettype none

// Complex arithmetic unit on signed fixed-point operands.
// A request is presented on action and the four operand ports with start high;
// it is taken at a rising edge where start is high and busy is low.
// Actions: add, subtract, multiply, divide, magnitude of a, negate a.
// Each result appears on res_real, res_imag and status for exactly one cycle,
// marked by done; results leave in request order after the queue, the stages
// and the output register. The receiver cannot hold results off.
// Throughput is one request per cycle: the divider produces one quotient bit
// per stage over 33 stages and the square root one digit per stage, with
// one 32 by 32 multiply stage ahead of them, so busy stays low in normal use.
// A small request queue sits between the front end and the pipeline.
// Overflowing parts saturate with status 2; a zero divisor returns zeros with
// status 1.
// Reset clears the queue and every stage valid flag; no result is pending after it.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS,
    parameter int QUEUE_DEPTH = cau_pkg::QUEUE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    action,
    input  wire logic signed [cau_pkg::DATA_W-1:0] a_real,
    input  wire logic signed [cau_pkg::DATA_W-1:0] a_imag,
    input  wire logic signed [cau_pkg::DATA_W-1:0] b_real,
    input  wire logic signed [cau_pkg::DATA_W-1:0] b_imag,
    output logic                               done,
    output logic signed [cau_pkg::DATA_W-1:0]  res_real,
    output logic signed [cau_pkg::DATA_W-1:0]  res_imag,
    output logic [1:0]                         status
);

    logic          full;
    logic          push;
    cau_pkg::req_t push_req;
    logic          pop;
    logic          head_valid;
    cau_pkg::req_t head_req;

    // Request intake and classification.
    cau_front u_front (
        .start    (start),
        .busy     (busy),
        .action   (action),
        .a_real   (a_real),
        .a_imag   (a_imag),
        .b_real   (b_real),
        .b_imag   (b_imag),
        .full     (full),
        .push     (push),
        .push_req (push_req)
    );

    // Queue between intake and execution.
    cau_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_req   (push_req),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_req   (head_req)
    );

    // Execution pipeline.
    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_req   (head_req),
        .pop        (pop),
        .done       (done),
        .res_real   (res_real),
        .res_imag   (res_imag),
        .status     (status)
    );

endmodule

`default_nettype wire

// ===== hdl/cau_front.sv =====
// Front end: accepts requests and classifies the action code.
`default_nettype none

module cau_front (
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    action,
    input  wire logic signed [cau_pkg::DATA_W-1:0] a_real,
    input  wire logic signed [cau_pkg::DATA_W-1:0] a_imag,
    input  wire logic signed [cau_pkg::DATA_W-1:0] b_real,
    input  wire logic signed [cau_pkg::DATA_W-1:0] b_imag,
    input  wire logic                          full,
    output logic                               push,
    output cau_pkg::req_t                      push_req
);

    // A request is taken whenever the queue has room.
    assign busy = full;
    assign push = start & ~full;

    // Map the action code to an operation class and pack the operands.
    always_comb
    begin
        if (action inside {[cau_pkg::OP_ADD:cau_pkg::OP_NEG]})
        begin
            push_req.op = cau_pkg::op_t'(action);
        end
        else
        begin
            push_req.op = cau_pkg::OP_NOP;
        end
        push_req.ar = a_real;
        push_req.ai = a_imag;
        push_req.br = b_real;
        push_req.bi = b_imag;
    end

endmodule

`default_nettype wire

// ===== hdl/cau_queue.sv =====
// Short request queue between the front end and the execution pipeline.
`default_nettype none

module cau_queue #(
    parameter int DEPTH = cau_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  cau_pkg::req_t      push_req,
    input  wire logic          pop,
    output logic               full,
    output logic               head_valid,
    output cau_pkg::req_t      head_req
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cau_pkg::req_t    entry_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_req = entry_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop = pop & head_valid;

    // Pointer and fill count updates, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cau_back.sv =====
// Execution pipeline: multiply, sum, pipelined divide and square root, round and saturate.
`default_nettype none

module cau_back #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      head_valid,
    input  cau_pkg::req_t                  head_req,
    output logic                           pop,
    output logic                           done,
    output logic [cau_pkg::DATA_W-1:0]     res_real,
    output logic [cau_pkg::DATA_W-1:0]     res_imag,
    output logic [1:0]                     status
);

    localparam int QB = cau_pkg::QBITS;
    localparam int RS = cau_pkg::ROOT_STEPS;
    localparam int PW = cau_pkg::PROD_W;
    localparam int SW = cau_pkg::SUM_W;
    localparam int MW = cau_pkg::MAG_W;
    localparam int DW = cau_pkg::DATA_W;
    localparam int RW = cau_pkg::ROOT_REM_W;

    cau_pkg::prod_t s1_next;
    cau_pkg::prod_t s1_reg;
    logic           s1_vld_reg;
    cau_pkg::sum_t  s2_next;
    cau_pkg::sum_t  s2_reg;
    logic           s2_vld_reg;
    cau_pkg::item_t s3_next;
    cau_pkg::item_t stg_reg [0:QB];
    logic           stg_vld_reg [0:QB];

    logic [SW-1:0]  abs1;
    logic [SW-1:0]  abs2;
    logic [PW-1:0]  mg1;
    logic [PW-1:0]  mg2;

    cau_pkg::item_t fin;
    logic [MW-1:0]  fm0;
    logic [MW-1:0]  fm1;
    cau_pkg::sat_t  fr0;
    cau_pkg::sat_t  fr1;
    logic [DW-1:0]  res_real_next;
    logic [DW-1:0]  res_imag_next;
    logic [1:0]     status_next;
    logic           done_reg;
    logic [DW-1:0]  res_real_reg;
    logic [DW-1:0]  res_imag_reg;
    logic [1:0]     status_reg;

    // The pipeline never stalls, so the queue head is taken whenever present.
    assign pop = head_valid;

    // Initial divider state for one part: remainder from the high numerator bits.
    function automatic cau_pkg::lane_t div_init(logic [PW-1:0] m, logic neg,
                                                logic [PW-1:0] den);
        cau_pkg::lane_t ln;
        logic [PW-1:0]  msh;
        begin
            msh = m << FRAC_BITS;
            ln.rem = m >> (QB - FRAC_BITS);
            ln.num = msh[QB-1:0];
            ln.quo = '0;
            ln.neg = neg;
            ln.sat = (ln.rem >= den);
            return ln;
        end
    endfunction

    // Product part scaled down by the fraction width with rounding, clamped to the lane width.
    function automatic cau_pkg::lane_t mul_init(logic [PW-1:0] m, logic neg);
        cau_pkg::lane_t ln;
        logic [PW:0]    rnd;
        logic [PW:0]    sh;
        begin
            rnd = {1'b0, m} + ((PW + 1)'(1) << (FRAC_BITS - 1));
            sh = rnd >> FRAC_BITS;
            ln.rem = '0;
            ln.num = '0;
            ln.neg = neg;
            ln.sat = 1'b0;
            if (|sh[PW:MW-1])
            begin
                ln.quo = {1'b1, {(MW - 1){1'b0}}};
            end
            else
            begin
                ln.quo = sh[MW-1:0];
            end
            return ln;
        end
    endfunction

    // One restoring division step: shift in a numerator bit, subtract if it fits.
    function automatic cau_pkg::lane_t lane_step(cau_pkg::lane_t ln, logic [PW-1:0] den);
        cau_pkg::lane_t nx;
        logic [PW:0]    r2;
        logic [PW:0]    diff;
        begin
            nx = ln;
            r2 = {ln.rem, ln.num[QB-1]};
            diff = r2 - {1'b0, den};
            if (r2 >= {1'b0, den})
            begin
                nx.rem = diff[PW-1:0];
                nx.quo = {ln.quo[MW-2:0], 1'b1};
            end
            else
            begin
                nx.rem = r2[PW-1:0];
                nx.quo = {ln.quo[MW-2:0], 1'b0};
            end
            nx.num = {ln.num[QB-2:0], 1'b0};
            return nx;
        end
    endfunction

    // One digit-by-digit square root step on two radicand bits.
    function automatic cau_pkg::root_t root_step(cau_pkg::root_t sq);
        cau_pkg::root_t nx;
        logic [RW-1:0]  r;
        logic [RW-1:0]  trial;
        begin
            nx = sq;
            r = {sq.rem[RW-3:0], sq.rad[PW-1:PW-2]};
            trial = {1'b0, sq.root, 2'b01};
            if (r >= trial)
            begin
                nx.rem = r - trial;
                nx.root = {sq.root[RS-2:0], 1'b1};
            end
            else
            begin
                nx.rem = r;
                nx.root = {sq.root[RS-2:0], 1'b0};
            end
            nx.rad = {sq.rad[PW-3:0], 2'b00};
            return nx;
        end
    endfunction

    // One iteration stage; only divide and magnitude items change.
    function automatic cau_pkg::item_t item_step(cau_pkg::item_t it, logic root_en);
        cau_pkg::item_t nx;
        begin
            nx = it;
            if (it.op == cau_pkg::OP_DIV)
            begin
                nx.l0 = lane_step(it.l0, it.den);
                nx.l1 = lane_step(it.l1, it.den);
            end
            if (it.op == cau_pkg::OP_MAG && root_en)
            begin
                nx.sq = root_step(it.sq);
            end
            return nx;
        end
    endfunction

    // Saturate a sign and magnitude to signed 32 bits.
    function automatic cau_pkg::sat_t sat_part(logic neg, logic [MW-1:0] mag);
        cau_pkg::sat_t s;
        logic [MW-1:0] nmag;
        begin
            nmag = '0 - mag;
            s.ovf = 1'b0;
            if (!neg && mag > MW'(32'h7FFF_FFFF))
            begin
                s.ovf = 1'b1;
                s.val = 32'h7FFF_FFFF;
            end
            else if (neg && mag > MW'(32'h8000_0000))
            begin
                s.ovf = 1'b1;
                s.val = 32'h8000_0000;
            end
            else
            begin
                s.val = neg ? nmag[DW-1:0] : mag[DW-1:0];
            end
            return s;
        end
    endfunction

    // Stage 1: all products and the plain sums.
    always_comb
    begin
        s1_next.op = head_req.op;
        s1_next.p1 = head_req.ar * head_req.br;
        s1_next.p2 = head_req.ai * head_req.bi;
        s1_next.p3 = head_req.ar * head_req.bi;
        s1_next.p4 = head_req.ai * head_req.br;
        if (head_req.op == cau_pkg::OP_MAG)
        begin
            s1_next.p5 = head_req.ar * head_req.ar;
            s1_next.p6 = head_req.ai * head_req.ai;
        end
        else
        begin
            s1_next.p5 = head_req.br * head_req.br;
            s1_next.p6 = head_req.bi * head_req.bi;
        end
        case (head_req.op)
            cau_pkg::OP_SUB:
            begin
                s1_next.sre = (DW + 1)'(head_req.ar) - (DW + 1)'(head_req.br);
                s1_next.sim = (DW + 1)'(head_req.ai) - (DW + 1)'(head_req.bi);
            end
            cau_pkg::OP_NEG:
            begin
                s1_next.sre = '0 - (DW + 1)'(head_req.ar);
                s1_next.sim = '0 - (DW + 1)'(head_req.ai);
            end
            default:
            begin
                s1_next.sre = (DW + 1)'(head_req.ar) + (DW + 1)'(head_req.br);
                s1_next.sim = (DW + 1)'(head_req.ai) + (DW + 1)'(head_req.bi);
            end
        endcase
    end

    // Stage 2: exact real and imaginary sums and the squared norm.
    always_comb
    begin
        s2_next.op = s1_reg.op;
        s2_next.den = $unsigned(s1_reg.p5) + $unsigned(s1_reg.p6);
        case (s1_reg.op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_NEG:
            begin
                s2_next.t1 = SW'(s1_reg.sre);
                s2_next.t2 = SW'(s1_reg.sim);
            end
            cau_pkg::OP_MUL:
            begin
                s2_next.t1 = SW'(s1_reg.p1) - SW'(s1_reg.p2);
                s2_next.t2 = SW'(s1_reg.p3) + SW'(s1_reg.p4);
            end
            cau_pkg::OP_DIV:
            begin
                s2_next.t1 = SW'(s1_reg.p1) + SW'(s1_reg.p2);
                s2_next.t2 = SW'(s1_reg.p4) - SW'(s1_reg.p3);
            end
            default:
            begin
                s2_next.t1 = '0;
                s2_next.t2 = '0;
            end
        endcase
    end

    // Stage 3: sign and magnitude, then the starting state for each operation.
    always_comb
    begin
        abs1 = s2_reg.t1[SW-1] ? ('0 - s2_reg.t1) : s2_reg.t1;
        abs2 = s2_reg.t2[SW-1] ? ('0 - s2_reg.t2) : s2_reg.t2;
        mg1 = abs1[PW-1:0];
        mg2 = abs2[PW-1:0];
        s3_next.op = s2_reg.op;
        s3_next.den = s2_reg.den;
        s3_next.div0 = (s2_reg.den == '0);
        s3_next.l0 = '0;
        s3_next.l1 = '0;
        s3_next.sq = '0;
        case (s2_reg.op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_NEG:
            begin
                s3_next.l0.quo = mg1[MW-1:0];
                s3_next.l0.neg = s2_reg.t1[SW-1];
                s3_next.l1.quo = mg2[MW-1:0];
                s3_next.l1.neg = s2_reg.t2[SW-1];
            end
            cau_pkg::OP_MUL:
            begin
                s3_next.l0 = mul_init(mg1, s2_reg.t1[SW-1]);
                s3_next.l1 = mul_init(mg2, s2_reg.t2[SW-1]);
            end
            cau_pkg::OP_DIV:
            begin
                s3_next.l0 = div_init(mg1, s2_reg.t1[SW-1], s2_reg.den);
                s3_next.l1 = div_init(mg2, s2_reg.t2[SW-1], s2_reg.den);
            end
            cau_pkg::OP_MAG:
            begin
                s3_next.sq.rad = s2_reg.den;
            end
            default:
            begin
                s3_next.l0 = '0;
            end
        endcase
    end

    // Final stage: divider and root rounding, saturation and status.
    always_comb
    begin
        fin = stg_reg[QB];
        fm0 = fin.l0.quo;
        fm1 = fin.l1.quo;
        if (fin.op == cau_pkg::OP_DIV)
        begin
            fm0 = fin.l0.sat ? {1'b1, {(MW - 1){1'b0}}} :
                  fin.l0.quo + MW'({fin.l0.rem, 1'b0} >= {1'b0, fin.den});
            fm1 = fin.l1.sat ? {1'b1, {(MW - 1){1'b0}}} :
                  fin.l1.quo + MW'({fin.l1.rem, 1'b0} >= {1'b0, fin.den});
        end
        else if (fin.op == cau_pkg::OP_MAG)
        begin
            fm0 = MW'(fin.sq.root) + MW'(fin.sq.rem > RW'(fin.sq.root));
            fm1 = '0;
        end
        fr0 = sat_part(fin.l0.neg, fm0);
        fr1 = sat_part(fin.l1.neg, fm1);
        if (fin.op == cau_pkg::OP_DIV && fin.div0)
        begin
            res_real_next = '0;
            res_imag_next = '0;
            status_next = cau_pkg::ST_DIV0;
        end
        else
        begin
            res_real_next = fr0.val;
            res_imag_next = fr1.val;
            status_next = (fr0.ovf | fr1.ovf) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
        end
    end

    // Valid flags of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            for (int k = 0; k <= QB; k++)
            begin
                stg_vld_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= head_valid;
            s2_vld_reg <= s1_vld_reg;
            stg_vld_reg[0] <= s2_vld_reg;
            for (int k = 0; k < QB; k++)
            begin
                stg_vld_reg[k+1] <= stg_vld_reg[k];
            end
            done_reg <= stg_vld_reg[QB];
        end
    end

    // Stage payloads; the divider runs one quotient bit per stage, the root one digit.
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        stg_reg[0] <= s3_next;
        for (int k = 0; k < QB; k++)
        begin
            stg_reg[k+1] <= item_step(stg_reg[k], k < RS);
        end
        res_real_reg <= res_real_next;
        res_imag_reg <= res_imag_next;
        status_reg <= status_next;
    end

    assign done = done_reg;
    assign res_real = res_real_reg;
    assign res_imag = res_imag_reg;
    assign status = status_reg;

endmodule

`default_nettype wire

// ===== dv/tb_complex_arithmetic_unit.sv =====
// Testbench for the complex arithmetic unit: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit;

    typedef struct {
        logic [2:0]         act;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
    } request_t;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [1:0]         st;
    } answer_t;

    localparam int TIMEOUT_CYCLES = 200000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         action = '0;
    logic signed [31:0] a_real = '0;
    logic signed [31:0] a_imag = '0;
    logic signed [31:0] b_real = '0;
    logic signed [31:0] b_imag = '0;
    logic               busy;
    logic               done;
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic [1:0]         status;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    int       gap_left = 0;
    int       sent_count = 0;
    int       error_count = 0;
    int       cycle_count = 0;

    complex_arithmetic_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
        .done(done), .res_real(res_real), .res_imag(res_imag), .status(status)
    );

    // Clock generation.
    always #6 clk = ~clk;

    // Saturate a sign and magnitude pair to 32 signed bits.
    function automatic logic signed [31:0] clip_part(input bit neg, input logic [127:0] mag,
                                                     inout bit ovf);
        if (!neg && mag > 128'h7FFF_FFFF)
        begin
            ovf = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (neg && mag > 128'h8000_0000)
        begin
            ovf = 1'b1;
            return 32'sh8000_0000;
        end
        return neg ? -mag[31:0] : mag[31:0];
    endfunction

    // Rounded square root, ties upward.
    function automatic logic [127:0] root_rounded(input logic [127:0] s);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int i = 32; i >= 0; i--)
        begin
            t = r | (128'd1 << i);
            if (t * t <= s)
                r = t;
        end
        if (s - r * r > r)
            r = r + 1;
        return r;
    endfunction

    // Compute the expected result of one request.
    function automatic answer_t cplx_result(input request_t q);
        answer_t a;
        bit ovf;
        logic signed [127:0] ar, ai, br, bi, x, y;
        logic [127:0] den, mx, my;
        ar = q.ar;
        ai = q.ai;
        br = q.br;
        bi = q.bi;
        ovf = 1'b0;
        a.re = '0;
        a.im = '0;
        a.st = cau_pkg::ST_OK;
        case (q.act)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_NEG:
            begin
                x = (q.act == cau_pkg::OP_ADD) ? ar + br :
                    (q.act == cau_pkg::OP_SUB) ? ar - br : -ar;
                y = (q.act == cau_pkg::OP_ADD) ? ai + bi :
                    (q.act == cau_pkg::OP_SUB) ? ai - bi : -ai;
                a.re = clip_part(x < 0, x < 0 ? -x : x, ovf);
                a.im = clip_part(y < 0, y < 0 ? -y : y, ovf);
            end
            cau_pkg::OP_MUL:
            begin
                x = ar * br - ai * bi;
                y = ar * bi + ai * br;
                mx = x < 0 ? -x : x;
                my = y < 0 ? -y : y;
                a.re = clip_part(x < 0,
                                 (mx + (128'd1 << (cau_pkg::FRAC_BITS - 1))) >> cau_pkg::FRAC_BITS,
                                 ovf);
                a.im = clip_part(y < 0,
                                 (my + (128'd1 << (cau_pkg::FRAC_BITS - 1))) >> cau_pkg::FRAC_BITS,
                                 ovf);
            end
            cau_pkg::OP_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                begin
                    a.st = cau_pkg::ST_DIV0;
                end
                else
                begin
                    x = ar * br + ai * bi;
                    y = ai * br - ar * bi;
                    mx = x < 0 ? -x : x;
                    my = y < 0 ? -y : y;
                    mx = ((mx << (cau_pkg::FRAC_BITS + 1)) + den) / (den << 1);
                    my = ((my << (cau_pkg::FRAC_BITS + 1)) + den) / (den << 1);
                    a.re = clip_part(x < 0, mx, ovf);
                    a.im = clip_part(y < 0, my, ovf);
                end
            end
            cau_pkg::OP_MAG:
            begin
                a.re = clip_part(1'b0, root_rounded(ar * ar + ai * ai), ovf);
            end
            default: ;
        endcase
        if (ovf)
            a.st = cau_pkg::ST_OVF;
        return a;
    endfunction

    // Operand values biased toward the range limits.
    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return $signed(32'($urandom_range(0, 8)) << 16) * ($urandom_range(0, 1) ? 1 : -1);
            4: return $signed(32'($urandom_range(0, 200000)) - 100000);
            5: return $signed($urandom()) >>> 12;
            default: return $signed($urandom());
        endcase
    endfunction

    // Driver: presents queued requests with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_answers.push_back(cplx_result('{action, a_real, a_imag, b_real, b_imag}));
                sent_count <= sent_count + 1;
            end
            if (start && busy)
            begin
                start <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                request_t q;
                q = pending_requests.pop_front();
                action <= q.act;
                a_real <= q.ar;
                a_imag <= q.ai;
                b_real <= q.br;
                b_imag <= q.bi;
                start <= 1'b1;
                // Alternate stretches of back-to-back requests with gappy ones.
                gap_left <= ((sent_count / 60) % 2 == 0) ? 0 : $urandom_range(0, 9);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks every result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected result re=%h im=%h st=%0d",
                         $time, res_real, res_imag, status);
                error_count = error_count + 1;
            end
            else
            begin
                answer_t e;
                e = expected_answers.pop_front();
                if (res_real !== e.re)
                begin
                    $display("%0t: res_real expected %h actual %h", $time, e.re, res_real);
                    error_count = error_count + 1;
                end
                if (res_imag !== e.im)
                begin
                    $display("%0t: res_imag expected %h actual %h", $time, e.im, res_imag);
                    error_count = error_count + 1;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        request_t q;
        // Directed requests: field extremes, every operation, zero divisor, unused codes.
        pending_requests.push_back('{cau_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1,
                                     -32'sh1});
        pending_requests.push_back('{cau_pkg::OP_ADD, 32'sh1, 32'sh2, 32'sh3, 32'sh4});
        pending_requests.push_back('{cau_pkg::OP_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh1,
                                     -32'sh1});
        pending_requests.push_back('{cau_pkg::OP_SUB, 32'sh0, 32'sh0, 32'sh8000_0000, 32'sh0});
        pending_requests.push_back('{cau_pkg::OP_MUL, 32'sh0002_0000, 32'sh0003_0000,
                                     32'sh0004_0000, -32'sh0001_0000});
        pending_requests.push_back('{cau_pkg::OP_MUL, 32'sh8000_0000, 32'sh8000_0000,
                                     32'sh8000_0000, 32'sh8000_0000});
        pending_requests.push_back('{cau_pkg::OP_MUL, 32'sh0000_8000, 32'sh0, 32'sh1, 32'sh0});
        pending_requests.push_back('{cau_pkg::OP_MUL, -32'sh0000_8000, 32'sh0, 32'sh1, 32'sh0});
        pending_requests.push_back('{cau_pkg::OP_DIV, 32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0});
        pending_requests.push_back('{cau_pkg::OP_DIV, 32'sh0005_0000, 32'sh0002_0000,
                                     32'sh0001_0000, -32'sh0003_0000});
        pending_requests.push_back('{cau_pkg::OP_DIV, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1,
                                     32'sh0});
        pending_requests.push_back('{cau_pkg::OP_DIV, 32'sh1, 32'sh0, 32'sh0000_0003, 32'sh0});
        pending_requests.push_back('{cau_pkg::OP_MAG, 32'sh0003_0000, 32'sh0004_0000, 32'sh0,
                                     32'sh0});
        pending_requests.push_back('{cau_pkg::OP_MAG, 32'sh8000_0000, 32'sh8000_0000, 32'sh0,
                                     32'sh0});
        pending_requests.push_back('{cau_pkg::OP_MAG, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 32'sh0});
        pending_requests.push_back('{cau_pkg::OP_NEG, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0,
                                     32'sh0});
        pending_requests.push_back('{cau_pkg::OP_NEG, 32'sh1, -32'sh1, 32'sh0, 32'sh0});
        pending_requests.push_back('{cau_pkg::OP_NOP, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh1,
                                     -32'sh1});
        pending_requests.push_back('{3'd7, 32'sh8000_0000, 32'sh1, 32'sh2, 32'sh3});
        // Random requests.
        for (int i = 0; i < 550; i++)
        begin
            q.act = 3'($urandom_range(0, 7));
            q.ar = pick_operand();
            q.ai = pick_operand();
            q.br = pick_operand();
            q.bi = pick_operand();
            if (q.act == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0)
            begin
                q.br = '0;
                q.bi = '0;
            end
            pending_requests.push_back(q);
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_requests.size() == 0 && !start);
        wait (expected_answers.size() == 0);
        repeat (60) @(posedge clk);
        if (error_count == 0 && expected_answers.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
